/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/mlpq_pkg.sv */
package mlpq_pkg;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic               func;
    logic [2:0]         priority_req;
    logic signed [31:0] item_value;
  } req_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] removed_value;
    logic [2:0]         removed_level;
  } rsp_item_t;

endpackage

/* rtl/multi_level_priority_queue_top.sv */
// Flow: IDLE takes an item into a register; EXEC then registers an insert (or
// overflow/underflow) result, or for a successful delete reads storage, and READ
// registers that result; both wait while a result is stalled. One item is worked
// at a time: a new item is taken the cycle after the previous result is registered.
// Reset (rst, synchronous): clears all head/tail pointers and level counts at once;
// the value storage is left uninitialised and needs no clearing pass.
`include "assert_macros.svh"

module multi_level_priority_queue_top #(
  parameter int LEVELS     = 8,
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  mlpq_pkg::req_item_t  req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output mlpq_pkg::rsp_item_t  rsp
);
  import mlpq_pkg::*;

  localparam int LW    = $clog2(LEVELS);
  localparam int SW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int AW    = LW + SW;
  localparam int WORDS = 1 << AW;

  // Sequencer: IDLE takes an item, EXEC decides and touches storage,
  // READ waits out the storage read of a delete.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  req_item_t req_q;

  // Per-level FIFO bookkeeping, small enough for flops.
  logic [SW-1:0] head  [LEVELS];
  logic [SW-1:0] tail  [LEVELS];
  logic [CW-1:0] count [LEVELS];

  // Value storage: one word per (level, slot), registered read.
  logic [DATA_WIDTH-1:0] mem [WORDS];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [LW-1:0]         del_lvl;

  logic          slot_free;
  logic          lvl_ok;
  logic [LW-1:0] ins_lvl;
  logic [LW-1:0] enc_lvl;
  logic          any_full_lvl;  // some level non-empty
  logic [LW-1:0] op_lvl;
  logic [CW-1:0] cnt_sel;
  logic [SW-1:0] head_sel;
  logic [SW-1:0] tail_sel;
  logic          do_insert;
  logic          do_delete;
  logic [AW-1:0] mem_addr;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  assign ins_lvl = LW'(req_q.priority_req);
  assign lvl_ok  = (32'(req_q.priority_req) < LEVELS);

  // Fixed priority encoder over occupancy: lowest non-empty level wins.
  always_comb begin
    enc_lvl      = '0;
    any_full_lvl = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        enc_lvl      = LW'(i);
        any_full_lvl = 1'b1;
      end
    end
  end

  assign op_lvl   = (req_q.func == FUNC_DELETE) ? enc_lvl : ins_lvl;
  assign cnt_sel  = count[op_lvl];
  assign head_sel = head[op_lvl];
  assign tail_sel = tail[op_lvl];

  // Only act once the result register can take the outcome.
  assign do_insert = (state == S_EXEC) && slot_free && (req_q.func == FUNC_INSERT) &&
                     lvl_ok && (cnt_sel != CW'(DEPTH));
  assign do_delete = (state == S_EXEC) && slot_free && (req_q.func == FUNC_DELETE) &&
                     any_full_lvl;

  assign mem_addr = {op_lvl, (req_q.func == FUNC_DELETE) ? head_sel : tail_sel};

  function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] s);
    return (s == SW'(DEPTH - 1)) ? '0 : s + SW'(1);
  endfunction

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) state_next = do_delete ? S_READ : S_IDLE;
      end
      S_READ: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) req_q <= req;
  end

  // Bookkeeping update; one level at most per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else if (do_insert) begin
      tail[op_lvl]  <= wrap_inc(tail_sel);
      count[op_lvl] <= cnt_sel + CW'(1);
    end else if (do_delete) begin
      head[op_lvl]  <= wrap_inc(head_sel);
      count[op_lvl] <= cnt_sel - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) mem[mem_addr] <= DATA_WIDTH'($unsigned(req_q.item_value));
  end

  always_ff @(posedge clk) begin
    if (do_delete) begin
      rd_data <= mem[mem_addr];
      del_lvl <= op_lvl;
    end
  end

  // Result register: holds until taken downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_EXEC && slot_free && !do_delete) begin
      rsp_valid <= 1'b1;
    end else if (state == S_READ && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && slot_free && !do_delete) begin
      rsp.removed_value <= '0;
      rsp.removed_level <= '0;
      if (req_q.func == FUNC_DELETE) begin
        rsp.status <= ST_UNDERFLOW;
      end else if (do_insert) begin
        rsp.status <= ST_INSERTED;
      end else begin
        rsp.status <= ST_OVERFLOW;
      end
    end else if (state == S_READ && slot_free) begin
      rsp.status        <= ST_DELETED;
      rsp.removed_value <= 32'(rd_data);
      rsp.removed_level <= 3'(del_lvl);
    end
  end

  // Occupancy of the level in play never passes the FIFO depth.
  `ASSERT_IMPL(a_count_bound, state == S_EXEC, cnt_sel <= CW'(DEPTH))
  // A result only appears out of the working states.
  `ASSERT_IMPL(a_rsp_origin, $rose(rsp_valid), $past(state == S_EXEC || state == S_READ))
  // A successful insert grows its level by exactly one.
  `ASSERT_NEXT(a_insert_count, do_insert, count[$past(op_lvl)] == $past(cnt_sel) + CW'(1))

endmodule

/* sim/multi_level_priority_queue_top_test.sv */
module multi_level_priority_queue_top_test;
  import mlpq_pkg::*;

  // Geometry as built: the instance uses the block's default parameters
  localparam int NUM_LEVELS   = 8;
  localparam int LEVEL_DEPTH  = 8;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no item moving on either side
  localparam int CALM_ITEMS   = 48;    // closing stretch with no idling at all
  localparam int SETTLE       = 8;     // allow margin after the last result
  localparam int REPORT_CAP   = 20;

  // Shapes of a random segment
  typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_kind_t;

  // One pending request; hold makes the sender wait for an empty scoreboard first
  typedef struct {
    req_item_t payload;
    bit        hold;
  } backlog_entry_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  multi_level_priority_queue_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial forever #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the queue: one circular FIFO per level, same widths as the block
  // ---------------------------------------------------------------------------
  logic signed [31:0] slot_value [NUM_LEVELS][LEVEL_DEPTH];
  logic [2:0]         rd_ptr     [NUM_LEVELS];
  logic [2:0]         wr_ptr     [NUM_LEVELS];
  logic [3:0]         fill       [NUM_LEVELS];

  backlog_entry_t request_backlog[$];
  rsp_item_t      predicted_rsp[$];

  // Tallies for the closing summary
  int n_inserted, n_deleted, n_overflow, n_underflow, n_ptr_wraps;
  logic [NUM_LEVELS-1:0] levels_filled = '0;
  int  error_count = 0;
  bit  req_taken   = 1'b0;
  bit  calm_tail   = 1'b0;

  function automatic logic [2:0] step_ptr(logic [2:0] p);
    return (p == 3'(LEVEL_DEPTH - 1)) ? 3'd0 : p + 3'd1;
  endfunction

  // Applies one accepted request to the shadow and returns the result it should give
  function automatic rsp_item_t apply_request(req_item_t r);
    rsp_item_t res;
    int        lvl;
    int        k;
    res.status        = ST_INSERTED;
    res.removed_value = '0;
    res.removed_level = '0;
    if (r.func == FUNC_INSERT) begin
      lvl = int'(r.priority_req);
      if (lvl >= NUM_LEVELS || fill[lvl] == 4'(LEVEL_DEPTH)) begin
        res.status = ST_OVERFLOW;
      end else begin
        slot_value[lvl][wr_ptr[lvl]] = r.item_value;
        if (wr_ptr[lvl] == 3'(LEVEL_DEPTH - 1)) n_ptr_wraps++;
        wr_ptr[lvl] = step_ptr(wr_ptr[lvl]);
        fill[lvl]   = fill[lvl] + 4'd1;
        if (fill[lvl] == 4'(LEVEL_DEPTH)) levels_filled[lvl] = 1'b1;
      end
    end else begin
      // fixed priority: lowest-numbered non-empty level wins
      lvl = -1;
      for (k = NUM_LEVELS - 1; k >= 0; k--)
        if (fill[k] != 4'd0) lvl = k;
      if (lvl < 0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        res.status        = ST_DELETED;
        res.removed_value = slot_value[lvl][rd_ptr[lvl]];
        res.removed_level = 3'(lvl);
        if (rd_ptr[lvl] == 3'(LEVEL_DEPTH - 1)) n_ptr_wraps++;
        rd_ptr[lvl] = step_ptr(rd_ptr[lvl]);
        fill[lvl]   = fill[lvl] - 4'd1;
      end
    end
    return res;
  endfunction

  function automatic void queue_request(logic f, logic [2:0] prio, logic signed [31:0] v,
                                        bit hold = 1'b0);
    backlog_entry_t e;
    e.payload.func         = f;
    e.payload.priority_req = prio;
    e.payload.item_value   = v;
    e.hold                 = hold;
    request_backlog.push_back(e);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: changes on the falling edge, holds a stalled item steady
  // ---------------------------------------------------------------------------
  int gap_left  = 0;
  int gap_pct   = 0;
  int presented = 0;

  always @(negedge clk) begin : drive_requests
    backlog_entry_t e;
    calm_tail <= (request_backlog.size() < CALM_ITEMS);
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = 0;
    end else if (req_valid && !req_taken) begin
      // stalled: item stays exactly as it is
    end else if (gap_left != 0) begin
      gap_left--;
      req_valid <= 1'b0;
    end else if (request_backlog.size() != 0 &&
                 !(request_backlog[0].hold && predicted_rsp.size() != 0)) begin
      e = request_backlog.pop_front();
      req       <= e.payload;
      req_valid <= 1'b1;
      // idle density changes now and then, sometimes to none
      if (presented % 32 == 0)
        gap_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 8);
      presented++;
      gap_left = (!calm_tail && $urandom_range(99) < gap_pct) ? $urandom_range(9, 1) : 0;
    end else begin
      req_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: stalls in random bursts, none near the end
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int stall_pct  = 0;
  int sink_cycle = 0;

  always @(negedge clk) begin : drive_sink
    if (sink_cycle % 64 == 0)
      stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(35, 5);
    sink_cycle++;
    if (rst || calm_tail) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(8, 0);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples on the rising edge, predicts on acceptance, checks in order
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin : watch_ports
    rsp_item_t want;
    rsp_item_t got;
    if (rst) begin
      req_taken <= 1'b0;
      quiet_cycles = 0;
    end else begin
      req_taken <= req_valid && !req_stall;
      if (req_valid && !req_stall)
        predicted_rsp.push_back(apply_request(req));
      if (rsp_valid && !rsp_stall) begin
        got = rsp;
        if (predicted_rsp.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_CAP)
            $display("%0t: unexpected result, expected none, got status %0d value %0d level %0d",
                     $time, got.status, got.removed_value, got.removed_level);
        end else begin
          want = predicted_rsp.pop_front();
          case (want.status)
            ST_INSERTED:  n_inserted++;
            ST_DELETED:   n_deleted++;
            ST_OVERFLOW:  n_overflow++;
            ST_UNDERFLOW: n_underflow++;
          endcase
          if (got.status !== want.status) begin
            error_count++;
            if (error_count <= REPORT_CAP)
              $display("%0t: status mismatch, expected %0d, got %0d",
                       $time, want.status, got.status);
          end
          if (got.removed_value !== want.removed_value) begin
            error_count++;
            if (error_count <= REPORT_CAP)
              $display("%0t: removed_value mismatch, expected %0d, got %0d",
                       $time, want.removed_value, got.removed_value);
          end
          if (got.removed_level !== want.removed_level) begin
            error_count++;
            if (error_count <= REPORT_CAP)
              $display("%0t: removed_level mismatch, expected %0d, got %0d",
                       $time, want.removed_level, got.removed_level);
          end
        end
      end
      // watchdog: nothing moving on either side for too long
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("** multi_level_priority_queue_top: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int        made;
    int        seg_len;
    seg_kind_t seg;
    logic [2:0] hot_a, hot_b, prio;
    int        ins_pct;
    bit        hold;

    foreach (fill[i]) begin
      fill[i]   = '0;
      rd_ptr[i] = '0;
      wr_ptr[i] = '0;
    end

    // directed: empty delete, value extremes at the outer levels, priority order
    queue_request(FUNC_DELETE, 3'd6, 32'sh1234_5678);   // underflow, junk in ignored fields
    queue_request(FUNC_INSERT, 3'd7, 32'sh7fff_ffff);
    queue_request(FUNC_INSERT, 3'd0, 32'sh8000_0000);
    queue_request(FUNC_INSERT, 3'd7, 32'shffff_ffff);
    queue_request(FUNC_INSERT, 3'd3, 32'sh0000_0000);
    repeat (4) queue_request(FUNC_DELETE, 3'($urandom), $urandom);  // levels 0, 3, 7, 7
    queue_request(FUNC_DELETE, 3'd0, 32'sh0);           // empty again
    // fill one level to the brim, one more overflows, then wrap its tail
    repeat (LEVEL_DEPTH + 1) queue_request(FUNC_INSERT, 3'd5, $urandom);
    queue_request(FUNC_DELETE, 3'd2, $urandom);
    queue_request(FUNC_INSERT, 3'd5, 32'sh5555_aaaa);

    // random: segments that fill a couple of hot levels, drain, or mix;
    // the first segment and some later ones start from an empty scoreboard
    made = 0;
    hold = 1'b1;
    while (made < RANDOM_ITEMS) begin
      seg_len = $urandom_range(40, 15);
      seg     = seg_kind_t'($urandom_range(2));
      hot_a   = 3'($urandom_range(7));
      hot_b   = 3'($urandom_range(7));
      ins_pct = (seg == SEG_FILL) ? 80 : (seg == SEG_DRAIN) ? 20 : 50;
      repeat (seg_len) begin
        if (seg != SEG_MIXED && $urandom_range(3) != 0)
          prio = $urandom_range(1) ? hot_a : hot_b;
        else
          prio = 3'($urandom_range(7));
        queue_request(($urandom_range(99) < ins_pct) ? FUNC_INSERT : FUNC_DELETE,
                      prio, $urandom, hold);
        hold = 1'b0;
        made++;
      end
      hold = ($urandom_range(3) == 0);
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // every item sent and every result back, then a short settle
    while (request_backlog.size() != 0 || req_valid || predicted_rsp.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Checked %0d results: %0d inserts, %0d deletes, %0d overflows, %0d underflows.",
             n_inserted + n_deleted + n_overflow + n_underflow,
             n_inserted, n_deleted, n_overflow, n_underflow);
    $display("Levels driven to full: %b; ring pointer wrap-arounds: %0d.",
             levels_filled, n_ptr_wraps);
    if (error_count == 0)
      $display("** multi_level_priority_queue_top: PASSED **");
    else
      $display("** multi_level_priority_queue_top: FAILED **");
    $finish;
  end

endmodule
